// ===== sv/dmwtc_pkg.sv =====
// Shared types, codes and byte helpers for the direct-mapped write-through cache.
`timescale 1ns / 1ps

package dmwtc_pkg;

  // Command codes of an input word
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FILL  = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_READ_DATA  = 3'd0;
  localparam logic [2:0] KIND_LINE_REQ   = 3'd1;
  localparam logic [2:0] KIND_WRITE_THRU = 3'd2;
  localparam logic [2:0] KIND_BYPASS     = 3'd3;
  localparam logic [2:0] KIND_REJECT     = 3'd4;

  // Config port: one 32-bit register, word index taken from paddr[2]
  localparam int unsigned PADDR_W = 3;
  localparam logic REG_LOCAL_CHIP_ID = 1'b0;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] address;
    logic [63:0] write_data;
    logic [3:0]  byte_count;
    logic [7:0]  destination;
    logic        fixed_addr;
    logic        vol_flag;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] address;
    logic [63:0] data;
    logic [3:0]  count;
    logic        hit;
  } result_t;

  // Zero counts as one byte; clip at the end of the 8-byte word.
  function automatic logic [3:0] clip_count(input logic [3:0] bc, input logic [2:0] off);
    logic [3:0] cnt;
    logic [3:0] room;
    cnt  = (bc == 4'd0) ? 4'd1 : bc;
    room = 4'd8 - {1'b0, off};
    return (cnt > room) ? room : cnt;
  endfunction

  function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
    logic [63:0] m;
    if (cnt >= 4'd8) begin
      m = '1;
    end else begin
      m = (64'd1 << {cnt[2:0], 3'b000}) - 64'd1;
    end
    return m;
  endfunction

endpackage

// ===== sv/dmwtc_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
`timescale 1ns / 1ps

module dmwtc_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/dmwtc_ctrl.sv =====
// Cache controller: lookup, read-modify-write, line fill sequencing, valid clear.
`timescale 1ns / 1ps

module dmwtc_ctrl import dmwtc_pkg::*; #(
  parameter int unsigned LINES      = 256,
  parameter int unsigned LINE_BYTES = 64,
  localparam int unsigned WPL     = LINE_BYTES / 8,
  localparam int unsigned OFF_W   = $clog2(LINE_BYTES),
  localparam int unsigned IDX_W   = $clog2(LINES),
  localparam int unsigned TAG_W   = 32 - OFF_W - IDX_W,
  localparam int unsigned DADDR_W = IDX_W + OFF_W - 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  item_t              item_i,
  input  logic [7:0]         local_chip_id_i,
  output logic               busy_o,
  output logic               valid_o,
  output result_t            result_o,
  // tag store: {valid, tag}
  output logic               tag_we_o,
  output logic [IDX_W-1:0]   tag_waddr_o,
  output logic [TAG_W:0]     tag_wdata_o,
  output logic [IDX_W-1:0]   tag_raddr_o,
  input  logic [TAG_W:0]     tag_rdata_i,
  // data store: one 64-bit word per entry
  output logic               data_we_o,
  output logic [DADDR_W-1:0] data_waddr_o,
  output logic [63:0]        data_wdata_o,
  output logic [DADDR_W-1:0] data_raddr_o,
  input  logic [63:0]        data_rdata_i
);

  localparam int unsigned FC_W = $clog2(WPL) + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_FILL_RD,
    ST_FILL_OUT
  } state_e;

  state_e           state_q;
  item_t            item_q;
  logic             pend_q;
  logic [FC_W-1:0]  fcnt_q;
  logic [31:0]      pend_addr_q;
  logic [3:0]       pend_cnt_q;
  logic [IDX_W-1:0] clr_q;
  logic             valid_q;
  result_t          res_q;

  logic             accept;
  logic [2:0]       off;
  logic [3:0]       cnt;
  logic [63:0]      mask;
  logic [5:0]       shamt;
  logic [IDX_W-1:0] idx;
  logic [TAG_W-1:0] tag;
  logic             bypass;
  logic             hit;
  logic             fill_last;
  logic [63:0]      wr_bytes;
  logic [63:0]      merged;
  logic [63:0]      rd_bytes;
  logic [63:0]      fill_bytes;
  logic [DADDR_W-1:0] fill_waddr;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // Lookup decode of the held access
  assign off    = item_q.address[2:0];
  assign cnt    = clip_count(item_q.byte_count, off);
  assign mask   = byte_mask(cnt);
  assign shamt  = {off, 3'b000};
  assign idx    = item_q.address[OFF_W+IDX_W-1:OFF_W];
  assign tag    = item_q.address[31:OFF_W+IDX_W];
  assign bypass = !item_q.fixed_addr || item_q.vol_flag ||
                  (item_q.destination != local_chip_id_i);
  assign hit    = tag_rdata_i[TAG_W] && (tag_rdata_i[TAG_W-1:0] == tag);

  assign wr_bytes   = item_q.write_data & mask;
  assign merged     = (data_rdata_i & ~(mask << shamt)) | (wr_bytes << shamt);
  assign rd_bytes   = (data_rdata_i >> shamt) & mask;
  assign fill_bytes = (data_rdata_i >> {pend_addr_q[2:0], 3'b000}) & byte_mask(pend_cnt_q);

  assign fill_last  = (fcnt_q == FC_W'(WPL - 1));
  assign fill_waddr = (DADDR_W'(pend_addr_q[OFF_W+IDX_W-1:OFF_W]) << (OFF_W - 3)) +
                      DADDR_W'(fcnt_q);

  // Read addresses: incoming access, or the pending word after the last fill
  assign tag_raddr_o  = item_i.address[OFF_W+IDX_W-1:OFF_W];
  assign data_raddr_o = (state_q == ST_FILL_RD) ? pend_addr_q[OFF_W+IDX_W-1:3]
                                                : item_i.address[OFF_W+IDX_W-1:3];

  always_comb begin
    tag_we_o     = 1'b0;
    tag_waddr_o  = idx;
    tag_wdata_o  = {1'b0, tag};
    data_we_o    = 1'b0;
    data_waddr_o = item_q.address[OFF_W+IDX_W-1:3];
    data_wdata_o = merged;
    unique case (state_q)
      ST_CLEAR: begin
        tag_we_o    = 1'b1;
        tag_waddr_o = clr_q;
        tag_wdata_o = '0;
      end
      ST_LOOKUP: begin
        case (item_q.command)
          CMD_FILL: begin
            if (pend_q) begin
              data_we_o    = 1'b1;
              data_waddr_o = fill_waddr;
              data_wdata_o = item_q.write_data;
              if (fill_last) begin
                tag_we_o    = 1'b1;
                tag_waddr_o = pend_addr_q[OFF_W+IDX_W-1:OFF_W];
                tag_wdata_o = {1'b1, pend_addr_q[31:OFF_W+IDX_W]};
              end
            end
          end
          CMD_READ: begin
            // miss: invalidate until the fill completes
            tag_we_o = !pend_q && !bypass && !hit;
          end
          CMD_WRITE: begin
            data_we_o = !pend_q && !bypass && hit;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      fcnt_q      <= '0;
      pend_addr_q <= '0;
      pend_cnt_q  <= 4'd1;
      valid_q     <= 1'b0;
      res_q       <= '0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == IDX_W'(LINES - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          state_q       <= ST_IDLE;
          res_q.address <= item_q.address;
          res_q.data    <= '0;
          res_q.count   <= cnt;
          res_q.hit     <= 1'b0;
          case (item_q.command)
            CMD_FILL: begin
              if (pend_q) begin
                if (fill_last) begin
                  pend_q  <= 1'b0;
                  fcnt_q  <= '0;
                  state_q <= ST_FILL_RD;
                end else begin
                  fcnt_q <= fcnt_q + 1'b1;
                end
              end
            end
            CMD_READ, CMD_WRITE: begin
              valid_q <= 1'b1;
              if (pend_q) begin
                res_q.kind <= KIND_REJECT;
              end else if (bypass) begin
                res_q.kind <= KIND_BYPASS;
                res_q.data <= (item_q.command == CMD_WRITE) ? wr_bytes : '0;
              end else if (item_q.command == CMD_WRITE) begin
                res_q.kind <= KIND_WRITE_THRU;
                res_q.data <= wr_bytes;
                res_q.hit  <= hit;
              end else if (hit) begin
                res_q.kind <= KIND_READ_DATA;
                res_q.data <= rd_bytes;
                res_q.hit  <= 1'b1;
              end else begin
                res_q.kind    <= KIND_LINE_REQ;
                res_q.address <= item_q.address & ~(32'(LINE_BYTES) - 32'd1);
                pend_q        <= 1'b1;
                fcnt_q        <= '0;
                pend_addr_q   <= item_q.address;
                pend_cnt_q    <= cnt;
              end
            end
            default: begin
            end
          endcase
        end
        ST_FILL_RD: begin
          state_q <= ST_FILL_OUT;
        end
        ST_FILL_OUT: begin
          state_q       <= ST_IDLE;
          valid_q       <= 1'b1;
          res_q.kind    <= KIND_READ_DATA;
          res_q.address <= pend_addr_q;
          res_q.data    <= fill_bytes;
          res_q.count   <= pend_cnt_q;
          res_q.hit     <= 1'b0;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

// ===== sv/direct_mapped_write_through_cache_top.sv =====
// Top level: config register, controller and the tag and data stores.
// A core access is taken, looked up the next cycle, and its word is on the result
//   ports the cycle after that. The stores are read synchronously, ahead of the
//   modify/write step. Fill words are written in the lookup step; after the last
//   one the block rereads the pending word (FILL_RD) and puts it out (FILL_OUT) as
//   the read data word. Reset: async, active low; then a clear sweep marks every line
//   invalid with busy high. Results are strobed for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps

module direct_mapped_write_through_cache_top import dmwtc_pkg::*; #(
  parameter int unsigned LINES      = 256,
  parameter int unsigned LINE_BYTES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // APB-style configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // command side
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command_i,
  input  logic [31:0]        address_i,
  input  logic [63:0]        write_data_i,
  input  logic [3:0]         byte_count_i,
  input  logic [7:0]         destination_i,
  input  logic               fixed_addr_i,
  input  logic               vol_flag_i,
  // result side
  output logic               valid_o,
  output logic [2:0]         kind_o,
  output logic [31:0]        out_address_o,
  output logic [63:0]        out_data_o,
  output logic [3:0]         out_count_o,
  output logic               hit_o
);

  localparam int unsigned WPL     = LINE_BYTES / 8;
  localparam int unsigned OFF_W   = $clog2(LINE_BYTES);
  localparam int unsigned IDX_W   = $clog2(LINES);
  localparam int unsigned TAG_W   = 32 - OFF_W - IDX_W;
  localparam int unsigned DADDR_W = IDX_W + OFF_W - 3;

  logic [7:0] chip_id_q;
  item_t      item;
  result_t    result;

  logic               tag_we;
  logic [IDX_W-1:0]   tag_waddr;
  logic [TAG_W:0]     tag_wdata;
  logic [IDX_W-1:0]   tag_raddr;
  logic [TAG_W:0]     tag_rdata;
  logic               data_we;
  logic [DADDR_W-1:0] data_waddr;
  logic [63:0]        data_wdata;
  logic [DADDR_W-1:0] data_raddr;
  logic [63:0]        data_rdata;

  // Config register: written in the APB access phase, word index in paddr[2].
  // Writes to any other word are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_id_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LOCAL_CHIP_ID)) begin
      chip_id_q <= pwdata[7:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LOCAL_CHIP_ID) ? {24'd0, chip_id_q} : 32'd0;

  assign item = '{
    command:     command_i,
    address:     address_i,
    write_data:  write_data_i,
    byte_count:  byte_count_i,
    destination: destination_i,
    fixed_addr:  fixed_addr_i,
    vol_flag:    vol_flag_i
  };

  dmwtc_ctrl #(
    .LINES      (LINES),
    .LINE_BYTES (LINE_BYTES)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .item_i          (item),
    .local_chip_id_i (chip_id_q),
    .busy_o          (busy),
    .valid_o         (valid_o),
    .result_o        (result),
    .tag_we_o        (tag_we),
    .tag_waddr_o     (tag_waddr),
    .tag_wdata_o     (tag_wdata),
    .tag_raddr_o     (tag_raddr),
    .tag_rdata_i     (tag_rdata),
    .data_we_o       (data_we),
    .data_waddr_o    (data_waddr),
    .data_wdata_o    (data_wdata),
    .data_raddr_o    (data_raddr),
    .data_rdata_i    (data_rdata)
  );

  // Tag store: one {valid, tag} entry per line
  dmwtc_ram #(
    .DEPTH (LINES),
    .WIDTH (TAG_W + 1)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

  // Data store: LINE_BYTES/8 words per line, indexed by {line, word}
  dmwtc_ram #(
    .DEPTH (LINES * WPL),
    .WIDTH (64)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (data_waddr),
    .wdata_i (data_wdata),
    .raddr_i (data_raddr),
    .rdata_o (data_rdata)
  );

  assign kind_o        = result.kind;
  assign out_address_o = result.address;
  assign out_data_o    = result.data;
  assign out_count_o   = result.count;
  assign hit_o         = result.hit;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the direct-mapped write-through cache.
`timescale 1ns / 1ps

module testbench;
  import dmwtc_pkg::*;

  // Geometry of the cache under test
  localparam int unsigned NUM_LINES      = 256;
  localparam int unsigned LINE_SIZE      = 64;
  localparam int unsigned WORDS_PER_LINE = LINE_SIZE / 8;
  localparam int unsigned TAG_MAX        = 32'hFFFF_FFFF / (LINE_SIZE * NUM_LINES);

  // Command code the block must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Register map: chip id in word 0, word 1 is not decoded
  localparam logic [PADDR_W-1:0] CHIP_ID_ADDR   = {REG_LOCAL_CHIP_ID, 2'b00};
  localparam logic [PADDR_W-1:0] SPARE_REG_ADDR = 3'd4;

  localparam int unsigned PHASES         = 4;
  localparam int unsigned PHASE_ACCESSES = 120;   // core accesses per random phase
  localparam int unsigned SETTLE_CYCLES  = 10;    // idle cycles after the last result
  localparam int unsigned STALL_LIMIT    = 2000;  // quiet cycles before giving up
  localparam int unsigned MAX_PRINTS     = 50;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // APB side
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Command side; drv_word holds what is on the input ports
  logic  start    = 1'b0;
  logic  busy;
  item_t drv_word = '0;

  // Result side
  logic        valid_o;
  logic [2:0]  kind_o;
  logic [31:0] out_address_o;
  logic [63:0] out_data_o;
  logic [3:0]  out_count_o;
  logic        hit_o;

  always #10 clk_i = ~clk_i;

  direct_mapped_write_through_cache_top #(
    .LINES      (NUM_LINES),
    .LINE_BYTES (LINE_SIZE)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .command_i     (drv_word.command),
    .address_i     (drv_word.address),
    .write_data_i  (drv_word.write_data),
    .byte_count_i  (drv_word.byte_count),
    .destination_i (drv_word.destination),
    .fixed_addr_i  (drv_word.fixed_addr),
    .vol_flag_i    (drv_word.vol_flag),
    .valid_o       (valid_o),
    .kind_o        (kind_o),
    .out_address_o (out_address_o),
    .out_data_o    (out_data_o),
    .out_count_o   (out_count_o),
    .hit_o         (hit_o)
  );

  // ---------------------------------------------------------------------------
  // Cache shadow: tag/data stores, fill tracking and the chip id register
  // ---------------------------------------------------------------------------
  bit          line_ok   [NUM_LINES];
  bit [31:0]   line_tag  [NUM_LINES];
  bit [63:0]   line_data [NUM_LINES * WORDS_PER_LINE];
  bit          fill_open   = 1'b0;
  int unsigned fill_count  = 0;
  logic [31:0] fill_addr   = '0;
  logic [3:0]  fill_bytes  = 4'd1;
  logic [7:0]  chip_id_now = 8'd0;

  item_t       pending_words  [$];   // stimulus not yet taken by the block
  result_t     expected_words [$];   // predicted result words, oldest first
  int unsigned idle_pct    = 0;
  int unsigned error_count = 0;

  logic [31:0] tag_pool [4];
  logic [31:0] idx_pool [8];

  function automatic int unsigned line_of(input logic [31:0] a);
    return (a / LINE_SIZE) % NUM_LINES;
  endfunction

  function automatic logic [31:0] tag_of(input logic [31:0] a);
    return a / (LINE_SIZE * NUM_LINES);
  endfunction

  function automatic int unsigned slot_of(input logic [31:0] a);
    return line_of(a) * WORDS_PER_LINE + (a % LINE_SIZE) / 8;
  endfunction

  function automatic logic [63:0] lane_mask(input logic [3:0] n);
    if (n >= 4'd8) begin
      return '1;
    end
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  // Apply one accepted input word to the shadow; queue the word it produces.
  task automatic predict_word(input item_t w);
    logic [2:0]  off;
    logic [3:0]  n;
    logic [63:0] m;
    logic [5:0]  sh;
    int unsigned row;
    int unsigned s;
    logic        hit;
    result_t     r;
    off = w.address[2:0];
    sh  = {off, 3'b000};
    if (w.command == CMD_FILL) begin
      if (!fill_open) begin
        return;                       // stray fill word
      end
      row = line_of(fill_addr);
      line_data[row * WORDS_PER_LINE + fill_count] = w.write_data;
      fill_count++;
      if (fill_count < WORDS_PER_LINE) begin
        return;
      end
      line_ok[row]  = 1'b1;
      line_tag[row] = tag_of(fill_addr);
      fill_open     = 1'b0;
      fill_count    = 0;
      r = '{KIND_READ_DATA, fill_addr,
            (line_data[slot_of(fill_addr)] >> {fill_addr[2:0], 3'b000}) & lane_mask(fill_bytes),
            fill_bytes, 1'b0};
      expected_words.push_back(r);
      return;
    end
    if (w.command == CMD_UNUSED) begin
      return;
    end

    // zero means one byte; never past the end of the 8-byte word
    n = (w.byte_count == 4'd0) ? 4'd1 : w.byte_count;
    if (n > 4'd8 - off) begin
      n = 4'd8 - off;
    end
    m = lane_mask(n);

    if (fill_open) begin
      r = '{KIND_REJECT, w.address, 64'd0, n, 1'b0};
    end else if (!w.fixed_addr || w.vol_flag || w.destination != chip_id_now) begin
      r = '{KIND_BYPASS, w.address, (w.command == CMD_WRITE) ? (w.write_data & m) : 64'd0,
            n, 1'b0};
    end else begin
      row = line_of(w.address);
      s   = slot_of(w.address);
      hit = line_ok[row] && line_tag[row] == tag_of(w.address);
      if (w.command == CMD_READ && hit) begin
        r = '{KIND_READ_DATA, w.address, (line_data[s] >> sh) & m, n, 1'b1};
      end else if (w.command == CMD_READ) begin
        line_ok[row] = 1'b0;
        fill_open    = 1'b1;
        fill_count   = 0;
        fill_addr    = w.address;
        fill_bytes   = n;
        r = '{KIND_LINE_REQ, w.address - (w.address % LINE_SIZE), 64'd0, n, 1'b0};
      end else begin
        // write through; the line changes only on a hit
        if (hit) begin
          line_data[s] = (line_data[s] & ~(m << sh)) | ((w.write_data & m) << sh);
        end
        r = '{KIND_WRITE_THRU, w.address, w.write_data & m, n, hit};
      end
    end
    expected_words.push_back(r);
  endtask

  task automatic flag_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic item_t core_word(input logic [1:0] cmd, input logic [31:0] a,
                                      input logic [63:0] d, input logic [3:0] bc,
                                      input logic [7:0] dest, input logic fx,
                                      input logic vol);
    item_t w;
    w = '{cmd, a, d, bc, dest, fx, vol};
    return w;
  endfunction

  // Mostly addresses from a small pool of lines, so hits, conflicts and
  // write-hit updates come up often; mostly aimed at this chip.
  function automatic item_t random_access(input logic [1:0] cmd);
    item_t w;
    w.command = cmd;
    if ($urandom_range(99) < 85) begin
      w.address = tag_pool[$urandom_range(3)] * (LINE_SIZE * NUM_LINES)
                + idx_pool[$urandom_range(7)] * LINE_SIZE + $urandom_range(LINE_SIZE - 1);
    end else begin
      w.address = $urandom;
    end
    w.write_data  = {$urandom, $urandom};
    w.byte_count  = ($urandom_range(99) < 75) ? 4'($urandom_range(8, 1))
                                              : 4'($urandom_range(15));
    w.destination = ($urandom_range(99) < 85) ? chip_id_now : 8'($urandom_range(255));
    w.fixed_addr  = $urandom_range(99) < 92;
    w.vol_flag    = $urandom_range(99) < 8;
    return w;
  endfunction

  // Finish the open line fill with random fill data.
  task automatic push_fill_words();
    item_t w;
    for (int i = fill_count; i < WORDS_PER_LINE; i++) begin
      w = random_access(CMD_FILL);
      pending_words.push_back(w);
    end
  endtask

  // Bring the block to rest: fill closed, every result in, nothing in flight.
  task automatic settle();
    while (pending_words.size() != 0) @(posedge clk_i);
    if (fill_open) begin
      push_fill_words();
    end
    while (pending_words.size() != 0 || expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // APB access
  // ---------------------------------------------------------------------------
  task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [31:0] d);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(input logic [PADDR_W-1:0] a, output logic [31:0] d);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    d = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_chip_id();
    logic [31:0] rd;
    apb_read(CHIP_ID_ADDR, rd);
    if (rd !== {24'd0, chip_id_now}) begin
      flag_mismatch($sformatf("chip id reads %h, want %h", rd, chip_id_now));
    end
  endtask

  task automatic program_chip_id(input logic [7:0] v);
    apb_write(CHIP_ID_ADDR, {24'd0, v});
    chip_id_now = v;
    check_chip_id();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present the oldest pending word, shadow it when the block takes it
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : driver
    if (rst_ni) begin
      if (start && !busy) begin
        predict_word(drv_word);
        void'(pending_words.pop_front());
      end
      if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start    <= 1'b1;
        drv_word <= pending_words[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result word against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    result_t want;
    if (rst_ni && valid_o !== 1'b0) begin
      if (expected_words.size() == 0) begin
        flag_mismatch($sformatf("unexpected word kind %0d addr %h", kind_o, out_address_o));
      end else begin
        want = expected_words.pop_front();
        if (kind_o !== want.kind)
          flag_mismatch($sformatf("kind %0d, want %0d (addr %h)", kind_o, want.kind,
                                  want.address));
        if (out_address_o !== want.address)
          flag_mismatch($sformatf("address %h, want %h", out_address_o, want.address));
        if (out_data_o !== want.data)
          flag_mismatch($sformatf("data %h, want %h (addr %h)", out_data_o, want.data,
                                  want.address));
        if (out_count_o !== want.count)
          flag_mismatch($sformatf("count %0d, want %0d (addr %h)", out_count_o, want.count,
                                  want.address));
        if (hit_o !== want.hit)
          flag_mismatch($sformatf("hit %b, want %b (addr %h)", hit_o, want.hit,
                                  want.address));
      end
    end
  end

  // Watchdog: too long with no accepted word, no result and no APB traffic
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || valid_o === 1'b1 || psel) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("testbench: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0]  phase_id   [PHASES];
    int unsigned phase_idle [PHASES];
    int unsigned produced;
    int unsigned sel;
    item_t       w;

    tag_pool[0] = 0;
    tag_pool[1] = TAG_MAX;
    tag_pool[2] = $urandom_range(TAG_MAX);
    tag_pool[3] = $urandom_range(TAG_MAX);
    idx_pool[0] = 0;
    idx_pool[1] = NUM_LINES - 1;
    for (int i = 2; i < 8; i++) idx_pool[i] = $urandom_range(NUM_LINES - 1);

    phase_id   = '{8'h00, 8'hFF, 8'($urandom_range(255)), 8'($urandom_range(255))};
    phase_idle = '{0, 51, 23, 0};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);   // clear sweep after reset

    // chip id comes up as zero; the undecoded register leaves it alone
    check_chip_id();
    apb_write(SPARE_REG_ADDR, $urandom);
    check_chip_id();

    // Directed words, chip id still at its reset value
    pending_words.push_back(core_word(CMD_READ, 32'h0000_0000, '0, 4'd8, 8'd0, 1'b1, 1'b0));
    for (int i = 0; i < WORDS_PER_LINE; i++) begin
      w = random_access(CMD_FILL);
      if (i == 0) w.write_data = 64'h0123_4567_89AB_CDEF;
      if (i == 1) w.write_data = '1;
      if (i == 2) w.write_data = '0;
      pending_words.push_back(w);
    end
    // hits: full word, clipped at word end, zero count
    pending_words.push_back(core_word(CMD_READ, 32'h0000_0000, '0, 4'd8, 8'd0, 1'b1, 1'b0));
    pending_words.push_back(core_word(CMD_READ, 32'h0000_0007, '0, 4'd8, 8'd0, 1'b1, 1'b0));
    pending_words.push_back(core_word(CMD_READ, 32'h0000_0002, '0, 4'd0, 8'd0, 1'b1, 1'b0));
    // write hit, clipped from 15 to 5 bytes, then read back
    pending_words.push_back(core_word(CMD_WRITE, 32'h0000_0003, '1, 4'd15, 8'd0, 1'b1, 1'b0));
    pending_words.push_back(core_word(CMD_READ, 32'h0000_0000, '0, 4'd8, 8'd0, 1'b1, 1'b0));
    pending_words.push_back(core_word(CMD_READ, 32'h0000_0008, '0, 4'd4, 8'd0, 1'b1, 1'b0));
    // write miss at the top of memory: no allocate
    pending_words.push_back(core_word(CMD_WRITE, 32'hFFFF_FFF8, '1, 4'd8, 8'd0, 1'b1, 1'b0));
    // bypasses: dynamic address, volatile, other chip
    pending_words.push_back(core_word(CMD_READ, 32'h0000_0000, '0, 4'd8, 8'd0, 1'b0, 1'b0));
    pending_words.push_back(core_word(CMD_WRITE, 32'h0000_0011, {$urandom, $urandom}, 4'd3,
                                      8'd0, 1'b1, 1'b1));
    pending_words.push_back(core_word(CMD_WRITE, 32'h0000_0020, '1, 4'd8, 8'hFF, 1'b1, 1'b0));
    // ignored: fill word with no fill open, unused command
    pending_words.push_back(core_word(CMD_FILL, $urandom, '1, 4'd8, 8'd0, 1'b1, 1'b0));
    pending_words.push_back(core_word(CMD_UNUSED, 32'h0000_0000, '1, 4'd8, 8'd0, 1'b1, 1'b0));
    // miss on the last line, then core words while it fills are rejected
    pending_words.push_back(core_word(CMD_READ, 32'hFFFF_FFC5, '0, 4'd6, 8'd0, 1'b1, 1'b0));
    pending_words.push_back(core_word(CMD_WRITE, 32'h0000_0000, '1, 4'd8, 8'd0, 1'b1, 1'b0));
    pending_words.push_back(core_word(CMD_READ, 32'h0000_0000, '0, 4'd8, 8'd0, 1'b1, 1'b0));
    settle();

    // Random phases, each at its own chip id and sender idle rate
    for (int p = 0; p < PHASES; p++) begin
      program_chip_id(phase_id[p]);
      idle_pct = phase_idle[p];
      produced = 0;
      while (produced < PHASE_ACCESSES) begin
        @(posedge clk_i);
        if (pending_words.size() == 0) begin
          sel = $urandom_range(99);
          if (fill_open) begin
            // mostly finish the fill; now and then a core word that gets rejected
            if (sel < 12) begin
              pending_words.push_back(random_access(sel < 6 ? CMD_READ : CMD_WRITE));
              produced++;
            end else begin
              push_fill_words();
            end
          end else if (sel < 45) begin
            pending_words.push_back(random_access(CMD_READ));
            produced++;
          end else if (sel < 88) begin
            pending_words.push_back(random_access(CMD_WRITE));
            produced++;
          end else if (sel < 95) begin
            pending_words.push_back(random_access(CMD_FILL));
          end else begin
            pending_words.push_back(random_access(CMD_UNUSED));
          end
        end
      end
      settle();
    end
    idle_pct = 0;

    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
